// ===== rtl/core/oaic_pkg.sv =====
`default_nettype none

package oaic_pkg;

    // The table size must be a power of two so that the hash and the probe
    // index both wrap by truncation.
    localparam int TABLE_SLOTS = 4096;
    localparam int PROBE_LIMIT = 32;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PROBE_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    localparam logic [63:0] GOLDEN_MULT    = 64'h9E37_79B9_7F4A_7C15;
    localparam int          KEY_DROP_SHIFT = 3;
    localparam int          HASH_SHIFT     = 40;

    // Only product bits below HASH_SHIFT + SLOT_W reach the slot index, so the
    // two cross products need just the low CROSS_W bits above bit 32.
    localparam int CROSS_W = HASH_SHIFT + SLOT_W - 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [2:0] ST_FOUND      = 3'd0;
    localparam logic [2:0] ST_MISS_EMPTY = 3'd1;
    localparam logic [2:0] ST_MISS_LIMIT = 3'd2;
    localparam logic [2:0] ST_INSERTED   = 3'd3;
    localparam logic [2:0] ST_PRESENT    = 3'd4;
    localparam logic [2:0] ST_NO_ROOM    = 3'd5;

    typedef struct packed {
        logic        opcode;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
    } rsp_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic start;
        logic probe;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic stop;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/oaic_dp.sv =====
`default_nettype none

module oaic_dp (
    input  wire            clk,
    input  wire            rst_n,
    input  oaic_pkg::cmd_t cmd,
    output oaic_pkg::sts_t sts,
    input  oaic_pkg::req_t req,
    output oaic_pkg::rsp_t rsp
);
    import oaic_pkg::*;

    logic                     valid_mem [TABLE_SLOTS];
    logic [63:0]              key_mem   [TABLE_SLOTS];
    logic [31:0]              value_mem [TABLE_SLOTS];

    logic                     op_reg;
    logic [63:0]              key_reg;
    logic [31:0]              val_reg;
    logic [CROSS_W-1:0]       p0_reg;
    logic [CROSS_W-1:0]       c1_reg;
    logic [CROSS_W-1:0]       c2_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [SLOT_W-1:0]        idx_next;
    logic [PROBE_W-1:0]       cnt_reg;
    logic [PROBE_W-1:0]       cnt_next;
    logic [SLOT_W-1:0]        clr_reg;
    logic                     rd_valid_reg;
    logic [63:0]              rd_key_reg;
    logic [31:0]              rd_value_reg;
    rsp_t                     rsp_reg;

    logic [63:0]              key_shr;
    logic [63:0]              p0_full;
    logic [2*CROSS_W-1:0]     c1_full;
    logic [2*CROSS_W-1:0]     c2_full;
    logic [CROSS_W-1:0]       hash_sum;
    logic [SLOT_W-1:0]        home;
    logic [SLOT_W-1:0]        rd_addr;
    logic                     rd_en;
    logic                     empty;
    logic                     hit;
    logic                     last;
    logic                     stop;
    logic                     wr_ins;
    rsp_t                     result;

    // The 61-bit by 64-bit product is split into one full 32x32 partial
    // product and two truncated cross products, all registered at accept.
    assign key_shr = req.key >> KEY_DROP_SHIFT;
    assign p0_full = 64'(key_shr[31:0]) * 64'(GOLDEN_MULT[31:0]);
    assign c1_full = (2*CROSS_W)'(key_shr[32+CROSS_W-1:32])
                   * (2*CROSS_W)'(GOLDEN_MULT[CROSS_W-1:0]);
    assign c2_full = (2*CROSS_W)'(key_shr[CROSS_W-1:0])
                   * (2*CROSS_W)'(GOLDEN_MULT[32+CROSS_W-1:32]);

    assign hash_sum = p0_reg + c1_reg + c2_reg;
    assign home     = hash_sum[CROSS_W-1:HASH_SHIFT-32];

    assign empty = !rd_valid_reg;
    assign hit   = rd_valid_reg && (rd_key_reg == key_reg);
    assign last  = (cnt_reg == PROBE_W'(PROBE_LIMIT - 1));
    assign stop  = empty || hit || last;

    assign rd_addr = cmd.start ? home : SLOT_W'(idx_reg + 1'b1);
    assign rd_en   = cmd.start || (cmd.probe && !stop);
    assign wr_ins  = cmd.probe && empty && (op_reg == OP_INSERT);

    always_comb
    begin
        result.found_value = '0;
        if (empty)
        begin
            result.status = (op_reg == OP_INSERT) ? ST_INSERTED : ST_MISS_EMPTY;
        end
        else if (hit)
        begin
            if (op_reg == OP_INSERT)
            begin
                result.status = ST_PRESENT;
            end
            else
            begin
                result.status      = ST_FOUND;
                result.found_value = rd_value_reg;
            end
        end
        else
        begin
            result.status = (op_reg == OP_INSERT) ? ST_NO_ROOM : ST_MISS_LIMIT;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            idx_next = home;
            cnt_next = '0;
        end
        else if (cmd.probe && !stop)
        begin
            idx_next = rd_addr;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
            val_reg <= req.value;
            p0_reg  <= p0_full[32+CROSS_W-1:32];
            c1_reg  <= c1_full[CROSS_W-1:0];
            c2_reg  <= c2_full[CROSS_W-1:0];
        end
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        if (cmd.probe && stop)
        begin
            rsp_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            valid_mem[clr_reg] <= 1'b0;
        end
        else if (wr_ins)
        begin
            valid_mem[idx_reg] <= 1'b1;
        end
        if (wr_ins)
        begin
            key_mem[idx_reg]   <= key_reg;
            value_mem[idx_reg] <= val_reg;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_key_reg   <= key_mem[rd_addr];
            rd_value_reg <= value_mem[rd_addr];
        end
    end

    assign sts.clr_last = (clr_reg == {SLOT_W{1'b1}});
    assign sts.stop     = stop;
    assign rsp          = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/oaic_ctrl.sv =====
`default_nettype none

module oaic_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output oaic_pkg::cmd_t cmd,
    input  oaic_pkg::sts_t sts
);
    import oaic_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ADDR  = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;
    logic   finish;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cmd.clr   = (state_reg == S_CLEAR);
        cmd.load  = (state_reg == S_IDLE) && req_valid;
        cmd.start = (state_reg == S_ADDR);
        // A probe that ends the walk waits until the output register is free.
        cmd.probe = (state_reg == S_PROBE) && (out_free || !sts.stop);
    end

    assign finish = cmd.probe && sts.stop;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/open_addressing_insert_once_cache.sv =====
// A transaction is registered at acceptance; its home slot is then read, and each
// probe checks one slot until an empty slot, a matching key or PROBE_LIMIT probes end it.
// Transactions are handled one at a time: req_stall stays high until the walk ends,
// and the single read port of the slot memories is used once per probe.
// Reset: asynchronous, active low; a clearing pass then empties each of the
// TABLE_SLOTS slots in turn, and req_stall stays high until it ends.
`default_nettype none

module open_addressing_insert_once_cache (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  oaic_pkg::req_t req,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output oaic_pkg::rsp_t rsp
);
    import oaic_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oaic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    oaic_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/oaic_chk.sv =====
`default_nettype none

module oaic_chk (
    input wire            clk,
    input wire            rst_n,
    input wire            req_valid,
    input wire            req_stall,
    input wire            rsp_valid,
    input wire            rsp_stall,
    input oaic_pkg::rsp_t rsp
);
    import oaic_pkg::*;

    // A held result must not change while the consumer stalls.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Items are handled one at a time, so an accepted transaction blocks the next.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input accepted in back-to-back cycles");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= ST_NO_ROOM))
        else $error("illegal status code");

    a_value_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_FOUND) |-> (rsp.found_value == '0))
        else $error("found_value nonzero without a hit");

endmodule

bind open_addressing_insert_once_cache oaic_chk u_chk (.*);

`default_nettype wire
